### rtl/core/lsgc_pkg.sv
// Shared types and constants for the growing-capacity LIFO stack.
package lsgc_pkg;

    // Command codes carried on cmd
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Smallest logical capacity
    localparam int MIN_CAP = 2;

    // Shift control handed from the controller to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

endpackage

### rtl/core/lsgc_cell.sv
// One storage cell of the shifting stack row.
module lsgc_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  lsgc_pkg::shift_ctl_t    ctl,
    input  logic [DATA_WIDTH-1:0]   up_data,
    input  logic [DATA_WIDTH-1:0]   down_data,
    output logic [DATA_WIDTH-1:0]   data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Take the upper neighbour on push, the lower one on pop, else hold
    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = up_data;
        end
        else if (ctl.pop)
        begin
            data_next = down_data;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/lsgc_ctrl.sv
// Count and capacity control with the registered result of each transaction.
module lsgc_ctrl #(
    parameter int MAX_DEPTH  = 64,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = $clog2(MAX_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             cmd,
    input  logic [DATA_WIDTH-1:0]  head_data,
    output lsgc_pkg::shift_ctl_t   ctl,
    output logic                   done,
    output logic [DATA_WIDTH-1:0]  top_value,
    output logic [1:0]             status,
    output logic [CNT_W-1:0]       entry_count,
    output logic [CNT_W-1:0]       capacity_now,
    output logic                   is_empty,
    output logic                   is_full
);

    localparam logic [CNT_W-1:0] MIN_CAP_C = CNT_W'(lsgc_pkg::MIN_CAP);
    localparam logic [CNT_W-1:0] MAX_C     = CNT_W'(MAX_DEPTH);
    localparam logic [CNT_W:0]   MAX_WIDE  = (CNT_W+1)'(MAX_DEPTH);

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic                   done_reg;
    logic [DATA_WIDTH-1:0]  top_reg, top_next;
    logic [1:0]             status_reg, status_next;
    logic [CNT_W-1:0]       cnt_out_reg;
    logic [CNT_W-1:0]       cap_out_reg;
    logic                   empty_reg, full_reg;
    logic [CNT_W:0]         grown;
    logic [CNT_W-1:0]       shrunk;
    logic [CNT_W-1:0]       count_dec;

    assign grown     = {cap_reg, 1'b0};
    assign shrunk    = (cap_reg >> 1) < MIN_CAP_C ? MIN_CAP_C : (cap_reg >> 1);
    assign count_dec = count_reg - CNT_W'(1);

    // Decode the transaction into new count, capacity, shift and result
    always_comb
    begin
        count_next  = count_reg;
        cap_next    = cap_reg;
        top_next    = '0;
        status_next = lsgc_pkg::ST_OK;
        ctl         = '0;
        if (accept)
        begin
            case (lsgc_pkg::cmd_t'(cmd))
                lsgc_pkg::CMD_PUSH:
                begin
                    if (count_reg >= MAX_C)
                    begin
                        status_next = lsgc_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        if (count_reg >= cap_reg)
                        begin
                            cap_next = (grown > MAX_WIDE) ? MAX_C : grown[CNT_W-1:0];
                        end
                        count_next = count_reg + CNT_W'(1);
                        ctl.push   = 1'b1;
                    end
                end
                lsgc_pkg::CMD_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = lsgc_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_dec;
                        top_next   = head_data;
                        ctl.pop    = 1'b1;
                        if ((cap_reg > MIN_CAP_C) && (count_dec <= (cap_reg >> 1)))
                        begin
                            cap_next = shrunk;
                        end
                    end
                end
                lsgc_pkg::CMD_PEEK:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = lsgc_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        top_next = head_data;
                    end
                end
                default:
                begin
                    count_next = '0;
                    cap_next   = MIN_CAP_C;
                end
            endcase
        end
    end

    // Hold the stack bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= MIN_CAP_C;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
            done_reg  <= accept;
        end
    end

    // Capture the result fields of the transaction
    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        status_reg  <= status_next;
        cnt_out_reg <= count_next;
        cap_out_reg <= cap_next;
        empty_reg   <= (count_next == '0);
        full_reg    <= (count_next == cap_next);
    end

    assign done         = done_reg;
    assign top_value    = top_reg;
    assign status       = status_reg;
    assign entry_count  = cnt_out_reg;
    assign capacity_now = cap_out_reg;
    assign is_empty     = empty_reg;
    assign is_full      = full_reg;

    // The count never passes the logical capacity
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("stored count above logical capacity");

    // The capacity stays within its bounds
    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg >= MIN_CAP_C) && (cap_reg <= MAX_C))
        else $error("logical capacity out of range");

    // A result follows each accepted transaction in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result after accepted transaction");

    // Overflow is only reported on a full memory
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (count_reg < MAX_C)) |=> (status != lsgc_pkg::ST_OVERFLOW))
        else $error("overflow reported with room left");

    // Push and pop never shift the row together
    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.push && ctl.pop))
        else $error("push and pop shift together");

endmodule

### rtl/core/lifo_stack_growing_capacity_core.sv
// A result strobes on done in the cycle after start is taken.
// Throughput: one transaction per cycle; busy stays low, and the cell row shifts on each push or pop.
// Each transaction moves the whole row of cells by at most one place, so no stall arises.
// The receiver cannot stall; every result is presented for exactly one cycle.
// Reset clears the entry count to 0 and the capacity to 2; cell contents stay undefined.
// Top level: row of shifting cells with the count and capacity controller.
module lifo_stack_growing_capacity_core #(
    parameter int MAX_DEPTH  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [DATA_WIDTH-1:0]               push_value,
    output logic                                done,
    output logic [DATA_WIDTH-1:0]               top_value,
    output logic [1:0]                          status,
    output logic [$clog2(MAX_DEPTH + 1)-1:0]    entry_count,
    output logic [$clog2(MAX_DEPTH + 1)-1:0]    capacity_now,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);

    lsgc_pkg::shift_ctl_t  ctl;
    logic                  accept;
    logic [DATA_WIDTH-1:0] cell_data [MAX_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    lsgc_ctrl #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .head_data    (cell_data[0]),
        .ctl          (ctl),
        .done         (done),
        .top_value    (top_value),
        .status       (status),
        .entry_count  (entry_count),
        .capacity_now (capacity_now),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    // Build the row: cell 0 holds the top, push moves entries deeper
    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] up_d;
        logic [DATA_WIDTH-1:0] down_d;

        if (i == 0)
        begin : g_head
            assign up_d = push_value;
        end
        else
        begin : g_body
            assign up_d = cell_data[i-1];
        end

        if (i == MAX_DEPTH - 1)
        begin : g_tail
            assign down_d = '0;
        end
        else
        begin : g_inner
            assign down_d = cell_data[i+1];
        end

        lsgc_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .up_data   (up_d),
            .down_data (down_d),
            .data      (cell_data[i])
        );
    end

endmodule

### tb/tb.sv
// Self-checking bench for the growing-capacity LIFO stack core: queued commands, shadow stack.
module tb;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_OPS  = 550;

    // One queued stack command; hold_off waits for all replies before it is offered
    typedef struct {
        lsgc_pkg::cmd_t    op;
        logic [WORD_W-1:0] value;
        bit                hold_off;
    } stack_op_t;

    // One reply of the stack as the shadow model predicts it
    typedef struct {
        logic [WORD_W-1:0]  top_value;
        lsgc_pkg::status_t  status;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] capacity_now;
        logic               is_empty;
        logic               is_full;
    } stack_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          cmd = lsgc_pkg::CMD_PUSH;
    logic [WORD_W-1:0]   push_value = '0;
    logic                busy;
    logic                done;
    logic [WORD_W-1:0]   top_value;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  entry_count;
    logic [COUNT_W-1:0]  capacity_now;
    logic                is_empty;
    logic                is_full;

    stack_op_t           op_queue[$];
    stack_reply_t        due_replies[$];

    // Shadow copy of the stack contents, fill level and logical capacity
    logic [WORD_W-1:0]   shadow_words[STACK_DEPTH];
    int                  shadow_depth = 0;
    int                  shadow_cap = lsgc_pkg::MIN_CAP;

    int                  error_count = 0;
    int                  cycle_count = 0;
    logic                took_op = 1'b0;
    int                  burst_left = 1;
    int                  gap_left = 0;

    lifo_stack_growing_capacity_core #(
        .MAX_DEPTH  (STACK_DEPTH),
        .DATA_WIDTH (WORD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .push_value   (push_value),
        .done         (done),
        .top_value    (top_value),
        .status       (status),
        .entry_count  (entry_count),
        .capacity_now (capacity_now),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    always #5 clk = ~clk;

    // Apply one command to the shadow stack and return the reply it should give
    function automatic stack_reply_t apply_stack_op(lsgc_pkg::cmd_t op,
                                                    logic [WORD_W-1:0] value);
        stack_reply_t r;
        int           grown;
        r.top_value = '0;
        r.status    = lsgc_pkg::ST_OK;
        case (op)
            lsgc_pkg::CMD_PUSH:
            begin
                if (shadow_depth >= STACK_DEPTH)
                begin
                    r.status = lsgc_pkg::ST_OVERFLOW;
                end
                else
                begin
                    if (shadow_depth >= shadow_cap)
                    begin
                        grown      = shadow_cap * 2;
                        shadow_cap = (grown > STACK_DEPTH) ? STACK_DEPTH : grown;
                    end
                    shadow_words[shadow_depth] = value;
                    shadow_depth++;
                end
            end
            lsgc_pkg::CMD_POP:
            begin
                if (shadow_depth == 0)
                begin
                    r.status = lsgc_pkg::ST_EMPTY;
                end
                else
                begin
                    shadow_depth--;
                    r.top_value = shadow_words[shadow_depth];
                    // shrink once the remaining count fits in half the capacity
                    if (shadow_cap > lsgc_pkg::MIN_CAP && shadow_depth <= shadow_cap / 2)
                    begin
                        shadow_cap = shadow_cap / 2;
                        if (shadow_cap < lsgc_pkg::MIN_CAP)
                        begin
                            shadow_cap = lsgc_pkg::MIN_CAP;
                        end
                    end
                end
            end
            lsgc_pkg::CMD_PEEK:
            begin
                if (shadow_depth == 0)
                begin
                    r.status = lsgc_pkg::ST_EMPTY;
                end
                else
                begin
                    r.top_value = shadow_words[shadow_depth - 1];
                end
            end
            default:
            begin
                shadow_depth = 0;
                shadow_cap   = lsgc_pkg::MIN_CAP;
            end
        endcase
        r.entry_count  = shadow_depth[COUNT_W-1:0];
        r.capacity_now = shadow_cap[COUNT_W-1:0];
        r.is_empty     = (shadow_depth == 0);
        r.is_full      = (shadow_depth == shadow_cap);
        return r;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h want %0h", cycle_count, field, got, want);
        error_count++;
    endtask

    task automatic add_op(lsgc_pkg::cmd_t op, logic [WORD_W-1:0] value, bit hold_off);
        stack_op_t item;
        item.op       = op;
        item.value    = value;
        item.hold_off = hold_off;
        op_queue.push_back(item);
    endtask

    // Mostly random words, with the all-zero and all-one patterns mixed in
    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    // Random hold-off flag for the pause-until-drained pressure case
    function automatic bit pick_hold();
        return ($urandom_range(0, 29) == 0);
    endfunction

    // Fill the stack past its memory limit, then drain it past empty
    task automatic add_fill_drain();
        int k;
        add_op(lsgc_pkg::CMD_CLEAR, pick_word(), pick_hold());
        for (k = 0; k < STACK_DEPTH + 2; k++)
        begin
            add_op(lsgc_pkg::CMD_PUSH, pick_word(), pick_hold());
        end
        add_op(lsgc_pkg::CMD_PEEK, pick_word(), 1'b0);
        for (k = 0; k < STACK_DEPTH + 2; k++)
        begin
            add_op(lsgc_pkg::CMD_POP, pick_word(), pick_hold());
        end
    endtask

    // Driver: present queued transactions at the falling edge in bursts and gaps
    always @(negedge clk)
    begin
        bit keep;
        bit go;
        keep = 1'b0;
        go   = 1'b0;
        if (rst_n)
        begin
            if (start && took_op)
            begin
                op_queue.delete(0);
            end
            keep = start && !took_op;
            if (keep)
            begin
                go = 1'b1;
            end
            else if (op_queue.size() != 0)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (!(op_queue[0].hold_off && due_replies.size() != 0))
                begin
                    go = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            start <= go;
            if (go)
            begin
                cmd        <= op_queue[0].op;
                push_value <= op_queue[0].value;
            end
        end
    end

    // Monitor: check each reply against the oldest prediction, then log new transactions
    always @(posedge clk)
    begin
        stack_reply_t want;
        if (!rst_n)
        begin
            took_op <= 1'b0;
        end
        else if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            cycle_count++;
            if (done)
            begin
                if (due_replies.size() == 0)
                begin
                    report_mismatch("unexpected reply, top_value", top_value, '0);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (top_value !== want.top_value)
                        report_mismatch("top_value", top_value, want.top_value);
                    if (status !== want.status)
                        report_mismatch("status", WORD_W'(status), WORD_W'(want.status));
                    if (entry_count !== want.entry_count)
                        report_mismatch("entry_count", WORD_W'(entry_count),
                                        WORD_W'(want.entry_count));
                    if (capacity_now !== want.capacity_now)
                        report_mismatch("capacity_now", WORD_W'(capacity_now),
                                        WORD_W'(want.capacity_now));
                    if (is_empty !== want.is_empty)
                        report_mismatch("is_empty", WORD_W'(is_empty), WORD_W'(want.is_empty));
                    if (is_full !== want.is_full)
                        report_mismatch("is_full", WORD_W'(is_full), WORD_W'(want.is_full));
                end
            end
            if (start && !busy)
            begin
                due_replies.push_back(apply_stack_op(lsgc_pkg::cmd_t'(cmd), push_value));
            end
            took_op <= start && !busy;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int seg;
        int n;
        int k;
        int r;
        int target;

        // Directed: extremes, every command, empty and shrink cases
        add_op(lsgc_pkg::CMD_PUSH,  32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_PUSH,  32'hFFFF_FFFF, 1'b0);
        add_op(lsgc_pkg::CMD_PEEK,  32'h1234_5678, 1'b0);
        add_op(lsgc_pkg::CMD_PUSH,  32'hA5A5_A5A5, 1'b0);
        add_op(lsgc_pkg::CMD_PEEK,  32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'hFFFF_FFFF, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_PEEK,  32'hFFFF_FFFF, 1'b0);
        add_op(lsgc_pkg::CMD_PUSH,  32'h5A5A_5A5A, 1'b0);
        add_op(lsgc_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_PEEK,  32'h0000_0000, 1'b0);
        for (k = 1; k <= 5; k++)
        begin
            add_op(lsgc_pkg::CMD_PUSH, k, 1'b0);
        end
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_POP,   32'h0000_0000, 1'b0);
        add_op(lsgc_pkg::CMD_CLEAR, 32'h0000_0000, 1'b0);

        // Random: start with a full fill to overflow, after a drained pause
        target = op_queue.size() + RANDOM_OPS;
        add_op(lsgc_pkg::CMD_PUSH, pick_word(), 1'b1);
        add_fill_drain();
        while (op_queue.size() < target)
        begin
            seg = $urandom_range(0, 15);
            if (seg == 15)
            begin
                add_fill_drain();
            end
            else if (seg >= 10 && seg <= 12)
            begin
                n = $urandom_range(1, 40);
                for (k = 0; k < n; k++)
                begin
                    add_op(lsgc_pkg::CMD_PUSH, pick_word(), pick_hold());
                end
            end
            else if (seg >= 13)
            begin
                n = $urandom_range(1, 40);
                for (k = 0; k < n; k++)
                begin
                    add_op(lsgc_pkg::CMD_POP, pick_word(), pick_hold());
                end
            end
            else
            begin
                n = $urandom_range(8, 30);
                for (k = 0; k < n; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        add_op(lsgc_pkg::CMD_PUSH, pick_word(), pick_hold());
                    else if (r < 78)
                        add_op(lsgc_pkg::CMD_POP, pick_word(), pick_hold());
                    else if (r < 94)
                        add_op(lsgc_pkg::CMD_PEEK, pick_word(), pick_hold());
                    else
                        add_op(lsgc_pkg::CMD_CLEAR, pick_word(), pick_hold());
                end
            end
        end

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to go out and every reply to come back
        while (op_queue.size() != 0 || start || due_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (error_count == 0 && due_replies.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
